FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSBP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MSBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSBP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hdl/msbp_pkg.sv
// Package for the MSB-first bit packer: field widths and default sizes.
// No dependencies.
`default_nettype none
package msbp_pkg;

  localparam int unsigned BIT_GROUP_W  = 32;
  localparam int unsigned BIT_COUNT_W  = 6;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BYTE_POS_W   = 12;
  localparam int unsigned PEND_W       = 7;

  localparam int unsigned MAX_BITS_DEFAULT     = 32;
  localparam int unsigned BUFFER_BYTES_DEFAULT = 4096;
  localparam int unsigned QUEUE_DEPTH          = 2;

endpackage
`default_nettype wire

FILE: hdl/msbp_ifs.sv
// Valid/ready channel interfaces for bit groups in and packed words out.
// Depends on msbp_pkg.
`default_nettype none
interface msbp_in_if import msbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BIT_GROUP_W-1:0] bit_group;
  logic [BIT_COUNT_W-1:0] bit_count;

  modport source (output valid, output bit_group, output bit_count, input ready);
  modport sink   (input valid, input bit_group, input bit_count, output ready);
endinterface

interface msbp_out_if import msbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     byte_out;
  logic [BYTE_POS_W-1:0] byte_pos;
  logic                  last_of_group;

  modport source (output valid, output byte_out, output byte_pos, output last_of_group,
                  input ready);
  modport sink   (input valid, input byte_out, input byte_pos, input last_of_group,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/msb_first_bit_packer.sv
// MSB-first bit packer, top level: front end, queue and back end.
// Depends on msbp_pkg, msbp_ifs, msbp_front, msbp_queue, msbp_back, assert_macros.svh.
//
// in_ch carries a group of bit_count bits (saturated at MAX_BITS), highest bit
// first. Held bits from earlier groups lead; every completed byte leaves on
// out_ch with its buffer index and a last_of_group mark on the final byte
// a group completes. Groups that complete no byte only add to the held bits.
// A group is accepted in any cycle the two-entry queue has room, so groups
// may arrive back to back. out_ch gives one byte per cycle while it is not
// stalled; at MAX_BITS = 32 a group completes up to four bytes. When the back
// end is idle, the first byte of a group passes the queue, the work register
// and the output register before it shows on out_ch. A stall on out_ch holds
// the output byte, then fills the queue, then drops in_ch.ready. Synchronous
// reset clears the held bits, the buffer index and all valid flags; there is
// no flush of held bits.
`default_nettype none
`include "assert_macros.svh"
module msb_first_bit_packer import msbp_pkg::*; #(
  parameter int unsigned MAX_BITS     = MAX_BITS_DEFAULT,
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  msbp_in_if.sink   in_ch,
  msbp_out_if.source out_ch
);

  localparam int unsigned ACC_W = MAX_BITS + PEND_W;
  localparam int unsigned NB_W  = $clog2(ACC_W / BYTE_W + 1);

  logic                  q_push, q_pop, q_full, q_empty;
  logic [ACC_W-1:0]      q_in_data, q_out_data;
  logic [NB_W-1:0]       q_in_nbytes, q_out_nbytes;

  msbp_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in_data),
    .q_nbytes (q_in_nbytes)
  );

  msbp_queue #(.WIDTH(ACC_W + NB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({q_in_data, q_in_nbytes}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  ({q_out_data, q_out_nbytes}),
    .empty (q_empty)
  );

  msbp_back #(.MAX_BITS(MAX_BITS), .BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_out_data),
    .q_nbytes (q_out_nbytes),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

  `MSBP_ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && q_full, "push into full queue")
  `MSBP_ASSERT(a_no_underflow, clk, rst_n, q_pop |-> !q_empty, "pop from empty queue")
  `MSBP_ASSERT(a_queued_has_bytes, clk, rst_n, !q_empty |-> (q_out_nbytes != '0), "empty word queued")

endmodule
`default_nettype wire

FILE: hdl/msbp_front.sv
// Front end: takes bit groups, merges them with held bits, queues aligned words.
// Depends on msbp_pkg and msbp_ifs.
`default_nettype none
module msbp_front import msbp_pkg::*; #(
  parameter int unsigned MAX_BITS = MAX_BITS_DEFAULT,
  localparam int unsigned ACC_W   = MAX_BITS + PEND_W,
  localparam int unsigned NB_W    = $clog2(ACC_W / BYTE_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  msbp_in_if.sink               in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [ACC_W-1:0]      q_data,
  output logic [NB_W-1:0]       q_nbytes
);

  logic [PEND_W-1:0]      pend_r;
  logic [2:0]             pcount_r;
  logic [BIT_COUNT_W-1:0] n;
  logic [BIT_GROUP_W-1:0] grp_m;
  logic [ACC_W-1:0]       acc;
  logic [6:0]             total;
  logic [6:0]             align_sh;
  logic                   accept;
  logic [PEND_W-1:0]      pend_nxt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    n = (in_ch.bit_count > BIT_COUNT_W'(MAX_BITS)) ? BIT_COUNT_W'(MAX_BITS) : in_ch.bit_count;
    grp_m    = in_ch.bit_group & ~({BIT_GROUP_W{1'b1}} << n);
    acc      = (ACC_W'(pend_r) << n) | ACC_W'(grp_m);
    total    = 7'(pcount_r) + 7'(n);
    align_sh = 7'(ACC_W) - total;
    // place the oldest bit at the top of the word
    q_data   = acc << align_sh;
    q_nbytes = NB_W'(total >> 3);
    q_push   = accept && (q_nbytes != '0);
    pend_nxt = PEND_W'(acc) & ~({PEND_W{1'b1}} << total[2:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      pcount_r <= '0;
    end else if (accept) begin
      pend_r   <= pend_nxt;
      pcount_r <= total[2:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/msbp_queue.sv
// Short register queue between the front and back ends.
// Depends on nothing but its parameters.
`default_nettype none
module msbp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/msbp_back.sv
// Back end: unloads queued words one byte per ready cycle; tracks buffer index.
// Depends on msbp_pkg and msbp_ifs.
`default_nettype none
module msbp_back import msbp_pkg::*; #(
  parameter int unsigned MAX_BITS     = MAX_BITS_DEFAULT,
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
  localparam int unsigned ACC_W       = MAX_BITS + PEND_W,
  localparam int unsigned NB_W        = $clog2(ACC_W / BYTE_W + 1),
  localparam int unsigned IDX_W       = $clog2(BUFFER_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire logic [ACC_W-1:0] q_data,
  input  wire logic [NB_W-1:0]  q_nbytes,
  output logic                  q_pop,
  msbp_out_if.source            out_ch
);

  logic [ACC_W-1:0]        work_data_r;
  logic [NB_W-1:0]         work_left_r;
  logic [IDX_W-1:0]        widx_r, widx_nxt;
  logic                    out_valid_r;
  logic [BYTE_W-1:0]       byte_r;
  logic [BYTE_POS_W-1:0]   idx_r;
  logic                    last_r;
  logic                    emit;

  assign emit  = (work_left_r != '0) && (!out_valid_r || out_ch.ready);
  // refill when idle or as the last byte of the current word leaves
  assign q_pop = !q_empty && ((work_left_r == '0) || (emit && (work_left_r == NB_W'(1))));
  assign widx_nxt = (widx_r == IDX_W'(BUFFER_BYTES - 1)) ? '0 : widx_r + 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_out      = byte_r;
  assign out_ch.byte_pos      = idx_r;
  assign out_ch.last_of_group = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      work_left_r <= '0;
      widx_r      <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        widx_r      <= widx_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        work_left_r <= q_nbytes;
      end else if (emit) begin
        work_left_r <= work_left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_data_r <= q_data;
    end else if (emit) begin
      work_data_r <= work_data_r << BYTE_W;
    end
    if (emit) begin
      byte_r <= work_data_r[ACC_W-1 -: BYTE_W];
      idx_r  <= BYTE_POS_W'(widx_r);
      last_r <= (work_left_r == NB_W'(1));
    end
  end

endmodule
`default_nettype wire
